### hdl/wsdf_pkg.sv
// websocket frame deframer package: parse phases, opcode and length codes
// used by the deframer top level and its port checker
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

  localparam int unsigned MaxLenW   = 17;
  localparam int unsigned LenW      = 64;
  localparam int unsigned KeyW      = 32;

  localparam logic [MaxLenW-1:0] MaxLenRst = 17'h10000;

  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASKKEY = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
    logic       too_long;
  } result_t;

endpackage

`default_nettype wire

### hdl/websocket_frame_deframer.sv
// websocket frame deframer top level: byte-wide frame header parser with
// payload unmasking; depends on wsdf_pkg
//
// channel  direction  handshake                    payload
// in       input      in_valid_i / in_stall_o      rx_byte_i, restart_i
// out      output     out_valid_o / out_stall_i    payload_byte_o, last_of_frame_o,
//                                                  empty_frame_o, too_long_o
// cfg      input      max_payload_len_we_i         max_payload_len_i
//
// one byte per cycle while the output is not stalled; an accepted request passes the input
// register, then the parser step writes its result into the result register
// the 64-bit length decrement and the oversize compare set the parser step path
// reset clears the parser and sets the length limit to 65536
// a stalled result holds the parser; the input register then fills and stalls the input
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer import wsdf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               restart_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              payload_byte_o,
  output logic                    last_of_frame_o,
  output logic                    empty_frame_o,
  output logic                    too_long_o,
  input  wire logic               max_payload_len_we_i,
  input  wire logic [MaxLenW-1:0] max_payload_len_i
);

  logic               in_valid_q;
  logic [7:0]         byte_q;
  logic               restart_q;
  logic [MaxLenW-1:0] max_len_q;

  phase_e             phase_q, phase_d;
  logic [3:0]         opcode_q, opcode_d;
  logic               mask_q, mask_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [3:0]         ext_q, ext_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [1:0]         midx_q, midx_d;

  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               res_v;
  logic               can_step;
  logic               fire;
  logic               hdr_done;
  logic               over;
  logic [7:0]         key_byte;

  assign can_step   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && can_step;
  assign in_stall_o = in_valid_q && !can_step;

  assign over     = (|len_d[LenW-1:MaxLenW]) || (len_d[MaxLenW-1:0] > max_len_q);
  assign key_byte = mask_q ? key_q[{~midx_q, 3'b000} +: 8] : 8'h00;

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    mask_d   = mask_q;
    len_d    = len_q;
    ext_d    = ext_q;
    key_d    = key_q;
    midx_d   = midx_q;
    res_v    = 1'b0;
    res_d    = '0;
    hdr_done = 1'b0;
    if (fire) begin
      if (restart_q) begin
        phase_d  = PH_HDR0;
        opcode_d = '0;
        mask_d   = 1'b0;
        len_d    = '0;
        ext_d    = '0;
        key_d    = '0;
        midx_d   = '0;
      end else begin
        unique case (phase_q)
          PH_HDR0: begin
            opcode_d = byte_q[3:0];
            phase_d  = PH_HDR1;
          end
          PH_HDR1: begin
            mask_d = byte_q[7];
            key_d  = '0;
            midx_d = '0;
            if (byte_q[6:0] == Len16Code || byte_q[6:0] == Len64Code) begin
              len_d   = '0;
              ext_d   = (byte_q[6:0] == Len16Code) ? Ext16Bytes : Ext64Bytes;
              phase_d = PH_EXTLEN;
            end else begin
              len_d = {{(LenW-7){1'b0}}, byte_q[6:0]};
              ext_d = '0;
              if (byte_q[7]) begin
                phase_d = PH_MASKKEY;
              end else begin
                hdr_done = 1'b1;
              end
            end
          end
          PH_EXTLEN: begin
            len_d = {len_q[LenW-9:0], byte_q};
            ext_d = ext_q - 4'd1;
            if (ext_d == 4'd0) begin
              if (mask_q) begin
                midx_d  = '0;
                phase_d = PH_MASKKEY;
              end else begin
                hdr_done = 1'b1;
              end
            end
          end
          PH_MASKKEY: begin
            key_d  = {key_q[KeyW-9:0], byte_q};
            midx_d = midx_q + 2'd1;
            if (midx_d == 2'd0) begin
              hdr_done = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            midx_d              = midx_q + 2'd1;
            len_d               = len_q - 64'd1;
            res_v               = 1'b1;
            res_d.payload_byte  = byte_q ^ key_byte;
            res_d.last_of_frame = (len_q == 64'd1);
            if (len_q == 64'd1) begin
              phase_d = PH_HDR0;
            end
          end
          PH_SKIP: begin
            if (len_q != '0) begin
              len_d = len_q - 64'd1;
            end
            if (len_q <= 64'd1) begin
              phase_d = PH_HDR0;
            end
          end
          default: begin
            phase_d  = PH_HDR0;
            opcode_d = '0;
            mask_d   = 1'b0;
            len_d    = '0;
            ext_d    = '0;
            key_d    = '0;
            midx_d   = '0;
          end
        endcase

        // header complete: route the frame
        if (hdr_done) begin
          midx_d = '0;
          if (opcode_q == OpBinary) begin
            priority if (over) begin
              phase_d             = PH_SKIP;
              res_v               = 1'b1;
              res_d.last_of_frame = 1'b1;
              res_d.too_long      = 1'b1;
            end else if (len_d == '0) begin
              phase_d             = PH_HDR0;
              res_v               = 1'b1;
              res_d.last_of_frame = 1'b1;
              res_d.empty_frame   = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            phase_d = (len_d == '0) ? PH_HDR0 : PH_SKIP;
          end
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q    <= rx_byte_i;
      restart_q <= restart_i;
    end
  end

  // length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenRst;
    end else if (max_payload_len_we_i) begin
      max_len_q <= max_payload_len_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      len_q    <= '0;
      ext_q    <= '0;
      key_q    <= '0;
      midx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      ext_q    <= ext_d;
      key_q    <= key_d;
      midx_q   <= midx_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_step) begin
      out_valid_q <= fire && res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_v) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = res_q.payload_byte;
  assign last_of_frame_o = res_q.last_of_frame;
  assign empty_frame_o   = res_q.empty_frame;
  assign too_long_o      = res_q.too_long;

endmodule

`default_nettype wire

### hdl/wsdf_port_checker.sv
// port-level checker for the websocket frame deframer and its bind
// depends on wsdf_pkg for the limit register width
`timescale 1ns / 1ps
`default_nettype none

module wsdf_port_checker import wsdf_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [7:0]         rx_byte_i,
  input wire logic               restart_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [7:0]         payload_byte_o,
  input wire logic               last_of_frame_o,
  input wire logic               empty_frame_o,
  input wire logic               too_long_o,
  input wire logic               max_payload_len_we_i,
  input wire logic [MaxLenW-1:0] max_payload_len_i
);

  // stalled request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(payload_byte_o) &&
      $stable(last_of_frame_o) && $stable(empty_frame_o) && $stable(too_long_o)))
    else $error("stalled output request changed");

  // empty frame result closes the frame with a zero byte
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_frame_o) |->
      (last_of_frame_o && !too_long_o && payload_byte_o == 8'h00))
    else $error("malformed empty frame result");

  // oversize result closes the frame with a zero byte
  a_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_long_o) |->
      (last_of_frame_o && !empty_frame_o && payload_byte_o == 8'h00))
    else $error("malformed oversize result");

  // nothing pending right out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind websocket_frame_deframer wsdf_port_checker u_wsdf_port_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .rx_byte_i           (rx_byte_i),
  .restart_i           (restart_i),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .payload_byte_o      (payload_byte_o),
  .last_of_frame_o     (last_of_frame_o),
  .empty_frame_o       (empty_frame_o),
  .too_long_o          (too_long_o),
  .max_payload_len_we_i(max_payload_len_we_i),
  .max_payload_len_i   (max_payload_len_i)
);

`default_nettype wire
